>>> rtl/spc_pkg.sv
// shared constants and types for the span clip and tile splitter
// no dependencies
package spc_pkg;

  localparam int MAX_CHUNKS = 64;
  localparam int CHUNK_CNT_W = $clog2(MAX_CHUNKS);

  localparam int COORD_W = 16;
  localparam int SIZE_W = 15;
  localparam int PHASE_W = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W = 3;

  // remainder unit: magnitude of (coordinate - phase) and step count
  localparam int DIVIDEND_W = 18;
  localparam int MAG_W = DIVIDEND_W - 1;
  localparam int REM_STEPS = MAG_W;
  localparam int REM_CNT_W = $clog2(REM_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_X = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_Y = 3'd7;

  typedef struct packed {
    logic                         start;
    logic signed [DIVIDEND_W-1:0] dividend;
    logic [SIZE_W-1:0]            divisor;
  } rem_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } rem_rsp_t;

endpackage

>>> rtl/spc_rem_unit.sv
// floored remainder unit, one restoring step per cycle
// depends on spc_pkg
module spc_rem_unit import spc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  typedef enum logic [1:0] {R_IDLE, R_RUN, R_FIX} rstate_t;

  rstate_t              state;
  logic [REM_CNT_W-1:0] cnt;
  logic [MAG_W-1:0]     mag;
  logic [SIZE_W-1:0]    acc;
  logic [SIZE_W-1:0]    div;
  logic                 neg;

  logic [SIZE_W:0]      shifted;
  logic                 geq;
  logic [SIZE_W:0]      diff;
  logic [SIZE_W-1:0]    acc_next;
  logic [MAG_W-1:0]     abs_in;

  always_comb begin
    shifted = {acc, mag[MAG_W-1]};
    geq = shifted >= {1'b0, div};
    diff = shifted - {1'b0, div};
    acc_next = geq ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
    abs_in = req.dividend[DIVIDEND_W-1] ? MAG_W'(-req.dividend) : req.dividend[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      rsp.done <= 1'b0;
      cnt <= '0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        R_IDLE: begin
          if (req.start) begin
            mag <= abs_in;
            neg <= req.dividend[DIVIDEND_W-1];
            div <= req.divisor;
            acc <= '0;
            cnt <= '0;
            state <= R_RUN;
          end
        end
        R_RUN: begin
          acc <= acc_next;
          mag <= {mag[MAG_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == REM_CNT_W'(REM_STEPS - 1)) state <= R_FIX;
        end
        R_FIX: begin
          // truncated remainder to floored remainder
          rsp.rem <= (neg && acc != '0) ? div - acc : acc;
          rsp.done <= 1'b1;
          state <= R_IDLE;
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/span_clip_tile_splitter_unit.sv
// span clip and tile splitter, top level with sequencer and chunk emitter
// depends on spc_pkg and spc_rem_unit
//
// A span is taken when start is high and busy is low. A span dropped by the clip
// box returns to idle after clipping; a solid span goes from clipping straight to
// its single chunk. A pattern span passes take-in, clipping and setup, then the two
// floored remainders (x and y source phase, 17 steps plus a fix-up and a hand-off
// on the shared remainder unit), then emits its chunks; with tile height zero the y
// remainder is skipped. Each chunk is shown for one cycle with out_valid high and
// cannot be held off by the receiver.
module span_clip_tile_splitter_unit import spc_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [COORD_W-1:0]   span_x,
  input  logic signed [COORD_W-1:0]   span_y,
  input  logic [SIZE_W-1:0]           span_width,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  output logic                        out_valid,
  output logic signed [COORD_W-1:0]   dest_x,
  output logic signed [COORD_W-1:0]   dest_y,
  output logic [COORD_W-1:0]          chunk_width,
  output logic [SIZE_W-1:0]           src_x,
  output logic [SIZE_W-1:0]           src_y,
  output logic                        last,
  output logic                        truncated
);

  typedef enum logic [2:0] {S_IDLE, S_CLIP, S_PREP, S_REMX, S_REMY, S_EMIT} state_t;

  state_t state;

  logic signed [COORD_W-1:0] clip_left, clip_top, clip_right, clip_bottom;
  logic [SIZE_W-1:0]         tile_width, tile_height;
  logic signed [PHASE_W-1:0] phase_x, phase_y;

  logic signed [COORD_W-1:0] in_x, in_y;
  logic [SIZE_W-1:0]         in_w;
  logic signed [COORD_W-1:0] pos, x_end;
  logic [SIZE_W-1:0]         sx, sy;
  logic [CHUNK_CNT_W-1:0]    n;

  rem_req_t req;
  rem_rsp_t rsp;

  logic signed [COORD_W:0]   x2_raw;
  logic signed [COORD_W-1:0] x1_clip;
  logic signed [COORD_W:0]   x2_clip;
  logic                      y_out, x_empty;
  logic [COORD_W:0]          remain;
  logic [COORD_W-1:0]        avail;
  logic [COORD_W-1:0]        w;
  logic                      fin, trunc;

  spc_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    x2_raw = (COORD_W+1)'(in_x) + (COORD_W+1)'($signed({1'b0, in_w}));
    x1_clip = (in_x < clip_left) ? clip_left : in_x;
    x2_clip = (x2_raw > (COORD_W+1)'(clip_right)) ? (COORD_W+1)'(clip_right) : x2_raw;
    y_out = (in_y < clip_top) || (in_y >= clip_bottom);
    x_empty = (COORD_W+1)'(x1_clip) >= x2_clip;

    req.start = (state == S_PREP)
             || (state == S_REMX && rsp.done && tile_height != '0);
    req.dividend = (state == S_PREP)
                 ? DIVIDEND_W'(pos) - DIVIDEND_W'(phase_x)
                 : DIVIDEND_W'(in_y) - DIVIDEND_W'(phase_y);
    req.divisor = (state == S_PREP) ? tile_width : tile_height;

    remain = (COORD_W+1)'(x_end) - (COORD_W+1)'(pos);
    avail = COORD_W'({1'b0, tile_width}) - COORD_W'(sx);
    if (tile_width == '0 || remain[COORD_W-1:0] <= avail) w = remain[COORD_W-1:0];
    else w = avail;
    fin = w == remain[COORD_W-1:0];
    trunc = !fin && n == CHUNK_CNT_W'(MAX_CHUNKS - 1);
    busy = state != S_IDLE;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left <= '0;
      clip_top <= '0;
      clip_right <= '0;
      clip_bottom <= '0;
      tile_width <= '0;
      tile_height <= SIZE_W'(1);
      phase_x <= '0;
      phase_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLIP_LEFT:   clip_left <= cfg_data[COORD_W-1:0];
        REG_CLIP_TOP:    clip_top <= cfg_data[COORD_W-1:0];
        REG_CLIP_RIGHT:  clip_right <= cfg_data[COORD_W-1:0];
        REG_CLIP_BOTTOM: clip_bottom <= cfg_data[COORD_W-1:0];
        REG_TILE_WIDTH:  tile_width <= cfg_data[SIZE_W-1:0];
        REG_TILE_HEIGHT: tile_height <= cfg_data[SIZE_W-1:0];
        REG_PHASE_X:     phase_x <= cfg_data[PHASE_W-1:0];
        REG_PHASE_Y:     phase_y <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      n <= '0;
    end else begin
      out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            in_x <= span_x;
            in_y <= span_y;
            in_w <= span_width;
            state <= S_CLIP;
          end
        end
        S_CLIP: begin
          pos <= x1_clip;
          x_end <= x2_clip[COORD_W-1:0];
          sx <= '0;
          sy <= '0;
          n <= '0;
          if (y_out || x_empty) state <= S_IDLE;
          else if (tile_width == '0) state <= S_EMIT;
          else state <= S_PREP;
        end
        S_PREP: state <= S_REMX;
        S_REMX: begin
          if (rsp.done) begin
            sx <= rsp.rem;
            state <= (tile_height == '0) ? S_EMIT : S_REMY;
          end
        end
        S_REMY: begin
          if (rsp.done) begin
            sy <= rsp.rem;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          out_valid <= 1'b1;
          dest_x <= pos;
          dest_y <= in_y;
          chunk_width <= w;
          src_x <= sx;
          src_y <= sy;
          last <= fin || trunc;
          truncated <= trunc;
          pos <= pos + w;
          sx <= '0;
          n <= n + 1'b1;
          if (fin || trunc) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/span_clip_tile_splitter_unit_test.sv
`timescale 1ns / 100ps
// testbench for span_clip_tile_splitter_unit: directed and random spans checked
// chunk by chunk against a predictor of the clip and tile split
// depends on spc_pkg and the unit under test
module span_clip_tile_splitter_unit_test;
  import spc_pkg::*;

  localparam int LIMIT = 300000;
  localparam int SETTLE = 48;

  typedef struct {
    logic signed [COORD_W-1:0] dest_x;
    logic signed [COORD_W-1:0] dest_y;
    logic [COORD_W-1:0]        width;
    logic [SIZE_W-1:0]         src_x;
    logic [SIZE_W-1:0]         src_y;
    logic                      last;
    logic                      truncated;
  } chunk_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] span_x = '0;
  logic signed [COORD_W-1:0] span_y = '0;
  logic [SIZE_W-1:0] span_width = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic signed [COORD_W-1:0] dest_x;
  logic signed [COORD_W-1:0] dest_y;
  logic [COORD_W-1:0] chunk_width;
  logic [SIZE_W-1:0] src_x;
  logic [SIZE_W-1:0] src_y;
  logic last;
  logic truncated;

  // predictor copy of the clip box and tile setup
  int box_left = 0;
  int box_top = 0;
  int box_right = 0;
  int box_bottom = 0;
  int pat_w = 0;
  int pat_h = 1;
  int org_x = 0;
  int org_y = 0;

  chunk_t want_chunks[$];
  int errors = 0;
  int cycle_count = 0;
  bit burst_mode = 0;

  span_clip_tile_splitter_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .span_x(span_x),
    .span_y(span_y),
    .span_width(span_width),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .dest_x(dest_x),
    .dest_y(dest_y),
    .chunk_width(chunk_width),
    .src_x(src_x),
    .src_y(src_y),
    .last(last),
    .truncated(truncated)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int floor_mod(int a, int d);
    int r;
    r = a % d;
    if (r < 0) r += d;
    return r;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // clip the span and cut it into tile aligned chunks
  function automatic void split_span(int x, int y, int w);
    int x1, x2, sx, sy, pos, cw, n;
    chunk_t c;
    x1 = x;
    x2 = x + w;
    n = 0;
    if (y < box_top || y >= box_bottom) return;
    if (x1 < box_left) x1 = box_left;
    if (x2 > box_right) x2 = box_right;
    if (x1 >= x2) return;
    c.dest_y = COORD_W'(y);
    if (pat_w == 0) begin
      c.dest_x = COORD_W'(x1);
      c.width = COORD_W'(x2 - x1);
      c.src_x = '0;
      c.src_y = '0;
      c.last = 1'b1;
      c.truncated = 1'b0;
      want_chunks.push_back(c);
      return;
    end
    sy = (pat_h == 0) ? 0 : floor_mod(y - org_y, pat_h);
    sx = floor_mod(x1 - org_x, pat_w);
    pos = x1;
    while (pos < x2) begin
      cw = x2 - pos;
      if (cw > pat_w - sx) cw = pat_w - sx;
      c.dest_x = COORD_W'(pos);
      c.width = COORD_W'(cw);
      c.src_x = SIZE_W'(sx);
      c.src_y = SIZE_W'(sy);
      c.last = 1'b0;
      c.truncated = 1'b0;
      if (pos + cw >= x2) begin
        c.last = 1'b1;
      end else if (n == MAX_CHUNKS - 1) begin
        c.last = 1'b1;
        c.truncated = 1'b1;
      end
      want_chunks.push_back(c);
      n++;
      if (c.last) break;
      pos += cw;
      sx = 0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch on %s at cycle %0d: got %0d, expected %0d", what, cycle_count, got,
             want);
  endtask

  // result checker
  always @(posedge clk) begin
    chunk_t c;
    if (!rst && out_valid) begin
      if (want_chunks.size() == 0) begin
        report_mismatch("unexpected chunk dest_x", dest_x, 0);
      end else begin
        c = want_chunks.pop_front();
        if (dest_x !== c.dest_x) report_mismatch("dest_x", dest_x, c.dest_x);
        if (dest_y !== c.dest_y) report_mismatch("dest_y", dest_y, c.dest_y);
        if (chunk_width !== c.width) report_mismatch("chunk_width", chunk_width, c.width);
        if (src_x !== c.src_x) report_mismatch("src_x", src_x, c.src_x);
        if (src_y !== c.src_y) report_mismatch("src_y", src_y, c.src_y);
        if (last !== c.last) report_mismatch("last", last, c.last);
        if (truncated !== c.truncated) report_mismatch("truncated", truncated, c.truncated);
      end
    end
  end

  // one span transaction; start stays high so back to back spans need no gap
  task automatic send_span(input int x, input int y, input int w);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    span_x <= COORD_W'(x);
    span_y <= COORD_W'(y);
    span_width <= SIZE_W'(w);
    do @(posedge clk); while (busy);
    split_span(x, y, w);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (want_chunks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      REG_CLIP_LEFT: box_left = $signed(value[15:0]);
      REG_CLIP_TOP: box_top = $signed(value[15:0]);
      REG_CLIP_RIGHT: box_right = $signed(value[15:0]);
      REG_CLIP_BOTTOM: box_bottom = $signed(value[15:0]);
      REG_TILE_WIDTH: pat_w = value & 'h7fff;
      REG_TILE_HEIGHT: pat_h = value & 'h7fff;
      REG_PHASE_X: org_x = $signed(value[16:0]);
      REG_PHASE_Y: org_y = $signed(value[16:0]);
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int cl, input int ct, input int cr, input int cb,
                            input int tw, input int th, input int px, input int py);
    wait_idle();
    write_reg(REG_CLIP_LEFT, cl);
    write_reg(REG_CLIP_TOP, ct);
    write_reg(REG_CLIP_RIGHT, cr);
    write_reg(REG_CLIP_BOTTOM, cb);
    write_reg(REG_TILE_WIDTH, tw);
    write_reg(REG_TILE_HEIGHT, th);
    write_reg(REG_PHASE_X, px);
    write_reg(REG_PHASE_Y, py);
  endtask

  // reset box is empty, so everything drops
  task automatic test_empty_box();
    send_span(0, 0, 10);
    send_span(-5, 0, 100);
  endtask

  task automatic test_solid_extremes();
    set_config(-32768, -32768, 32767, 32767, 0, 1, 0, 0);
    send_span(-32768, -32768, 32767);
    send_span(0, 0, 32767);
    send_span(32767, 0, 5);
    send_span(100, 32767, 10);
    send_span(5, 5, 0);
  endtask

  task automatic test_clip_edges();
    set_config(-100, -50, 100, 50, 0, 1, 0, 0);
    send_span(-200, 0, 150);
    send_span(50, 0, 200);
    send_span(-300, 0, 100);
    send_span(-100, -50, 200);
    send_span(0, 49, 1);
    send_span(0, 50, 5);
  endtask

  task automatic test_inverted_box();
    set_config(10, 0, 10, 100, 0, 1, 0, 0);
    send_span(0, 5, 50);
    set_config(0, 20, 100, 20, 3, 1, 0, 0);
    send_span(0, 20, 50);
  endtask

  task automatic test_tile_pattern();
    set_config(-1000, -1000, 1000, 1000, 7, 5, -3, -65536);
    send_span(-20, -7, 30);
    send_span(3, 3, 1);
    send_span(994, 999, 100);
    set_config(-32768, -32768, 32767, 32767, 32767, 32767, 65535, -65536);
    send_span(-32768, -32768, 32767);
    send_span(32000, 32766, 767);
  endtask

  task automatic test_zero_tile_height();
    set_config(-500, -500, 500, 500, 4, 0, 1, 7);
    send_span(-3, -9, 11);
    send_span(490, 499, 20);
  endtask

  task automatic test_chunk_limit();
    set_config(-32768, -32768, 32767, 32767, 1, 3, 0, 0);
    send_span(0, 1, 64);
    send_span(0, 2, 65);
    send_span(-32768, -1, 32767);
    set_config(-32768, -32768, 32767, 32767, 2, 3, 1, 0);
    send_span(0, 0, 129);
  endtask

  task automatic random_setup(input int k);
    int cl, ct, cr, cb, tw, th, px, py, cx, cy, tmp, r;
    if (k == 0) begin
      set_config(-32768, -32768, 32767, 32767, 1, 1, -65536, -65536);
      return;
    end
    if (k == 1) begin
      set_config(-32768, -32768, 32767, 32767, 32767, 32767, 65535, 65535);
      return;
    end
    cx = int'($urandom_range(0, 65535)) - 32768;
    cy = int'($urandom_range(0, 65535)) - 32768;
    cl = clamp_coord(cx - int'($urandom_range(0, 3000)));
    cr = clamp_coord(cx + int'($urandom_range(0, 3000)));
    ct = clamp_coord(cy - int'($urandom_range(0, 200)));
    cb = clamp_coord(cy + int'($urandom_range(0, 200)));
    if ($urandom_range(0, 9) == 0) begin
      tmp = cl;
      cl = cr;
      cr = tmp;
    end
    r = $urandom_range(0, 7);
    if (r < 2) tw = 0;
    else if (r == 2) tw = $urandom_range(0, 32767);
    else tw = $urandom_range(1, 60);
    r = $urandom_range(0, 7);
    if (r == 0) th = 0;
    else if (r == 1) th = $urandom_range(0, 32767);
    else th = $urandom_range(1, 20);
    px = int'($urandom_range(0, 131071)) - 65536;
    py = int'($urandom_range(0, 131071)) - 65536;
    set_config(cl, ct, cr, cb, tw, th, px, py);
  endtask

  task automatic test_random_spans();
    int x, y, w, r;
    for (int k = 0; k < 10; k++) begin
      random_setup(k);
      burst_mode = (k % 3 == 2);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 39) == 0) wait_idle();
        if ($urandom_range(0, 6) == 0 || box_right <= box_left || box_bottom <= box_top)
            begin
          x = int'($urandom_range(0, 65535)) - 32768;
          y = int'($urandom_range(0, 65535)) - 32768;
          w = $urandom_range(0, 32767);
        end else begin
          r = $urandom_range(0, 9);
          if (r == 0) y = box_top - 1;
          else if (r == 1) y = box_bottom;
          else y = box_top + int'($urandom_range(0, box_bottom - box_top - 1));
          y = clamp_coord(y);
          x = clamp_coord(box_left - int'($urandom_range(0, 64)) +
                          int'($urandom_range(0, box_right - box_left)));
          r = $urandom_range(0, 9);
          if (r == 0) w = 0;
          else if (r == 1) w = $urandom_range(0, 32767);
          else w = $urandom_range(1, 300);
        end
        send_span(x, y, w);
      end
    end
    burst_mode = 0;
  endtask

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_box();
    test_solid_extremes();
    test_clip_edges();
    test_inverted_box();
    test_tile_pattern();
    test_zero_tile_height();
    test_chunk_limit();
    test_random_spans();
    wait_idle();
    if (errors == 0 && want_chunks.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
